### sv/wrv_pkg.sv
// Package for the windowed realized volatility block.
// Holds the fixed field widths, constants and the controller state type.
// No dependencies.
package wrv_pkg;

  // Widths of the channel fields and of the window register.
  localparam int PRICE_W = 24;
  localparam int VOL_W   = 24;
  localparam int MARK_W  = 12;
  localparam int CFG_W   = 9;
  // Count of prices seen; saturates at window plus one, at most 512.
  localparam int SEEN_W  = 10;

  localparam logic [CFG_W-1:0]  DEFAULT_WINDOW = 9'd32;
  localparam logic [CFG_W-1:0]  MIN_WINDOW     = 9'd2;
  localparam logic [SEEN_W-1:0] MIN_SEEN       = 10'd3;
  localparam logic [VOL_W-1:0]  VOL_MAX        = 24'hFFFFFF;
  localparam logic [MARK_W-1:0] MARKER_CAP     = 12'd2560;
  localparam logic [3:0]        MARKER_SCALE   = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } wrv_state_t;

endpackage

### sv/wrv_ifs.sv
// Valid/ready channel interfaces for the price input and the result output.
// Depends on wrv_pkg for the field widths.
interface wrv_in_if import wrv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] close_price;

  modport source (output valid, output close_price, input ready);
  modport sink   (input valid, input close_price, output ready);
endinterface

interface wrv_out_if import wrv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOL_W-1:0]  volatility;
  logic [MARK_W-1:0] marker_size;

  modport source (output valid, output volatility, output marker_size, input ready);
  modport sink   (input valid, input volatility, input marker_size, output ready);
endinterface

### sv/windowed_realized_volatility.sv
// Top level of the windowed realized volatility block (rolling RMS of price differences).
// Depends on wrv_pkg and on the channel interfaces in wrv_ifs.sv.
//
//  Channel   Direction  Beat contents
//  in_ch     sink       close_price (Q16.8, unsigned)
//  out_ch    source     volatility (Q16.8), marker_size (Q4.8)
//  cfg_*     write      window_length (9 bits), clears the history
//
// A price that gives a result passes through the read, update, divide, square root and
// output states; the first price of a history only loads the previous price, and the second stops after the update.
// The restoring divider (one quotient bit a cycle) and the square root unit (one root bit a
// cycle) work in turn.
// Reset is synchronous and active low; the ring memory needs no clearing pass.
// A result waits in the output register; the next price is accepted meanwhile, and the
// block stalls only at the end of that price's work if the result is still not taken.
module windowed_realized_volatility import wrv_pkg::*; #(
  parameter int WINDOW_MAX = 256,
  parameter int PRICE_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  wrv_in_if.sink           in_ch,
  wrv_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int P_W    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int SQ2_W  = 2 * P_W;
  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SQ2_W + PTR_W;
  localparam int X_W    = SUM_W + (SUM_W % 2);
  localparam int RT_W   = X_W / 2;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int WPC_W  = (PTR_W > CFG_W) ? PTR_W : CFG_W;
  localparam int CMP_W  = (RT_W > VOL_W) ? RT_W : VOL_W;
  localparam int MK_W   = VOL_W + 4;
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(RT_W - 1);

  // Controller state and history registers.
  wrv_state_t          state_r, state_nxt;
  logic [CFG_W-1:0]    n_r;
  logic [P_W-1:0]      prev_r;
  logic [PTR_W-1:0]    wp_r;
  logic [SEEN_W-1:0]   seen_r;
  logic [SUM_W-1:0]    sum_r;

  // Per-item working registers.
  logic [P_W-1:0]      price_r;
  logic [P_W-1:0]      diff_r;
  logic [SQ2_W-1:0]    sq_r;
  logic [PTR_W-1:0]    addr_r;
  logic                full_r;
  logic [SUM_W-1:0]    dq_r;
  logic [CFG_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [X_W-1:0]      x_r;
  logic [RT_W-1:0]     root_r;
  logic [RT_W:0]       srem_r;

  // Output register.
  logic                out_valid_r;
  logic [VOL_W-1:0]    vol_r;
  logic [MARK_W-1:0]   mark_r;

  // Ring of squared differences.
  logic [SQ2_W-1:0]    ring [WINDOW_MAX];
  logic [SQ2_W-1:0]    rd_q;

  // Combinational helpers.
  logic                in_fire;
  logic                ring_we;
  logic                out_load;
  logic [P_W-1:0]      price_in;
  logic [P_W-1:0]      diff_in;
  logic [31:0]         win_wide;
  logic [CFG_W-1:0]    n_cfg;
  logic [SUM_W-1:0]    sum_new;
  logic [PTR_W:0]      wp_inc;
  logic [PTR_W-1:0]    wp_new;
  logic [SEEN_W-1:0]   seen_new;
  logic [CFG_W:0]      rem_sh;
  logic                div_ge;
  logic [RT_W+1:0]     srem_sh;
  logic [RT_W+1:0]     trial;
  logic                sqrt_ge;
  logic [CMP_W-1:0]    root_ext;
  logic [VOL_W-1:0]    vol_sat;
  logic [MK_W-1:0]     mark_wide;
  logic [MARK_W-1:0]   mark_sat;

  // Effective window of a register write: small values fall back to the default, large ones clamp to WINDOW_MAX.
  always_comb begin
    win_wide = (cfg_wdata < MIN_WINDOW) ? 32'(DEFAULT_WINDOW) : 32'(cfg_wdata);
    if (win_wide > 32'(WINDOW_MAX)) begin
      win_wide = 32'(WINDOW_MAX);
    end
    n_cfg = CFG_W'(win_wide);
  end

  // Price of the incoming beat and its distance to the previous price.
  assign price_in = in_ch.close_price[P_W-1:0];
  assign diff_in  = (price_in >= prev_r) ? (price_in - prev_r) : (prev_r - price_in);

  // History update: drop the oldest square once the window is full, add the new one.
  always_comb begin
    sum_new  = sum_r - (full_r ? SUM_W'(rd_q) : '0) + SUM_W'(sq_r);
    wp_inc   = (PTR_W+1)'(addr_r) + 1'b1;
    wp_new   = ((WPC_W+1)'(wp_inc) >= (WPC_W+1)'(n_r)) ? '0 : wp_inc[PTR_W-1:0];
    seen_new = (seen_r < (SEEN_W'(n_r) + 1'b1)) ? (seen_r + 1'b1) : seen_r;
  end

  // One restoring division step by the window length.
  always_comb begin
    rem_sh = {rem_r, dq_r[SUM_W-1]};
    div_ge = (rem_sh >= {1'b0, n_r});
  end

  // One square root step: two radicand bits in, one root bit out.
  always_comb begin
    srem_sh = {srem_r[RT_W-1:0], x_r[X_W-1:X_W-2]};
    trial   = {root_r, 2'b01};
    sqrt_ge = (srem_sh >= trial);
  end

  // Saturated volatility and the clamped marker size.
  always_comb begin
    root_ext  = CMP_W'(root_r);
    vol_sat   = (root_ext > CMP_W'(VOL_MAX)) ? VOL_MAX : VOL_W'(root_ext);
    mark_wide = MK_W'(vol_sat) * MK_W'(MARKER_SCALE);
    mark_sat  = (mark_wide > MK_W'(MARKER_CAP)) ? MARKER_CAP : MARK_W'(mark_wide);
  end

  // Controller outputs.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    in_fire     = in_ch.valid && (state_r == ST_IDLE);
    ring_we     = (state_r == ST_UPDATE);
    out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.volatility  = vol_r;
  assign out_ch.marker_size = mark_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (seen_r != '0)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = (seen_new >= MIN_SEEN) ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Ring memory: one synchronous read and one write port on the same address.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[addr_r] <= sq_r;
    end
    rd_q <= ring[addr_r];
  end

  // Control state, history and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= (32'(DEFAULT_WINDOW) > 32'(WINDOW_MAX)) ? CFG_W'(WINDOW_MAX)
                                                            : DEFAULT_WINDOW;
      prev_r      <= '0;
      wp_r        <= '0;
      seen_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        n_r    <= n_cfg;
        prev_r <= '0;
        wp_r   <= '0;
        seen_r <= '0;
        sum_r  <= '0;
      end else if (in_fire && (seen_r == '0)) begin
        prev_r <= price_in;
        seen_r <= SEEN_W'(1);
      end else if (state_r == ST_UPDATE) begin
        prev_r <= price_r;
        wp_r   <= wp_new;
        seen_r <= seen_new;
        sum_r  <= sum_new;
      end
    end
  end

  // Datapath working registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          price_r <= price_in;
          diff_r  <= diff_in;
          addr_r  <= ((WPC_W)'(wp_r) >= (WPC_W)'(n_r)) ? '0 : wp_r;
          full_r  <= ((seen_r - 1'b1) >= SEEN_W'(n_r));
        end
      end
      ST_READ: begin
        sq_r <= SQ2_W'(diff_r) * SQ2_W'(diff_r);
      end
      ST_UPDATE: begin
        dq_r  <= sum_new;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_ge ? CFG_W'(rem_sh - {1'b0, n_r}) : CFG_W'(rem_sh);
        dq_r  <= {dq_r[SUM_W-2:0], div_ge};
        if (cnt_r == DIV_LAST) begin
          x_r    <= X_W'({dq_r[SUM_W-2:0], div_ge});
          root_r <= '0;
          srem_r <= '0;
          cnt_r  <= '0;
        end else begin
          cnt_r  <= cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        srem_r <= sqrt_ge ? (RT_W+1)'(srem_sh - trial) : (RT_W+1)'(srem_sh);
        root_r <= {root_r[RT_W-2:0], sqrt_ge};
        x_r    <= {x_r[X_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
      end
      ST_OUT: begin
        if (out_load) begin
          vol_r  <= vol_sat;
          mark_r <= mark_sat;
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for windowed_realized_volatility (rolling RMS of price steps).
// Depends on wrv_pkg, the channel interfaces in wrv_ifs.sv and the block itself.
// Random prices and window settings are checked against a cycle-free model.
module testbench;
  import wrv_pkg::*;

  localparam int WINDOW_LIMIT = 256;
  localparam int PRICE_MAX    = (1 << PRICE_W) - 1;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD    = 1000;
  localparam int HOLD_AT_BEAT = 150;

  typedef struct packed {
    logic [VOL_W-1:0]  vol;
    logic [MARK_W-1:0] marker;
  } vol_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  wrv_in_if  in_ch();
  wrv_out_if out_ch();

  windowed_realized_volatility dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Prices waiting to be sent and results waiting to arrive.
  logic [PRICE_W-1:0] price_queue[$];
  vol_result_t        expected_results[$];

  // Model state of the volatility window.
  int          win_n;
  int          prices_seen;
  int          ring_ptr;
  logic [PRICE_W-1:0] last_price;
  logic [63:0] square_sum;
  logic [47:0] diff_ring[WINDOW_LIMIT];

  int    offered_cnt = 0;
  int    taken_cnt   = 0;
  int    result_cnt  = 0;
  int    fail_count  = 0;
  int    cycle_cnt   = 0;
  int    walk_price  = 24'h400000;
  logic  idle_on     = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Window register value to the number of differences actually averaged.
  function automatic int window_from_reg(logic [CFG_W-1:0] v);
    if (v < MIN_WINDOW) return int'(DEFAULT_WINDOW);
    if (int'(v) > WINDOW_LIMIT) return WINDOW_LIMIT;
    return int'(v);
  endfunction

  function automatic void clear_window_history();
    prices_seen = 0;
    ring_ptr    = 0;
    last_price  = '0;
    square_sum  = '0;
  endfunction

  // Bitwise integer square root, truncated.
  function automatic logic [31:0] int_sqrt(logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if ({32'd0, trial} * {32'd0, trial} <= x) root = trial;
    end
    return root;
  endfunction

  // Update the window with one price and queue the volatility it gives, if any.
  function automatic void predict_volatility(logic [PRICE_W-1:0] price);
    logic [PRICE_W-1:0] diff;
    logic [47:0]        sq;
    logic [63:0]        mean;
    logic [31:0]        root;
    logic [31:0]        marker;
    vol_result_t        res;
    if (prices_seen == 0) begin
      last_price  = price;
      prices_seen = 1;
      return;
    end
    diff = (price >= last_price) ? price - last_price : last_price - price;
    sq = {24'd0, diff} * {24'd0, diff};
    // Once the ring is full the oldest square drops out of the sum.
    if (prices_seen - 1 >= win_n) square_sum = square_sum - {16'd0, diff_ring[ring_ptr]};
    diff_ring[ring_ptr] = sq;
    square_sum = square_sum + {16'd0, sq};
    ring_ptr = (ring_ptr + 1 >= win_n) ? 0 : ring_ptr + 1;
    last_price = price;
    if (prices_seen < win_n + 1) prices_seen++;
    if (prices_seen < int'(MIN_SEEN)) return;
    mean = square_sum / 64'(win_n);
    root = int_sqrt(mean);
    if (root > {8'd0, VOL_MAX}) root = {8'd0, VOL_MAX};
    marker = root * 32'(MARKER_SCALE);
    if (marker > {20'd0, MARKER_CAP}) marker = {20'd0, MARKER_CAP};
    res.vol    = root[VOL_W-1:0];
    res.marker = marker[MARK_W-1:0];
    expected_results.push_back(res);
  endfunction

  // Mostly a random walk with steps of varied size, plus noise and the rails.
  function automatic logic [PRICE_W-1:0] next_price();
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      step = $urandom_range(0, 1 << $urandom_range(0, 16));
      if ($urandom_range(0, 1) == 1)
        walk_price = (walk_price > PRICE_MAX - step) ? PRICE_MAX : walk_price + step;
      else
        walk_price = (walk_price < step) ? 0 : walk_price - step;
      return walk_price[PRICE_W-1:0];
    end
    if (pick < 85) return PRICE_W'($urandom_range(0, PRICE_MAX));
    return ($urandom_range(0, 1) == 1) ? PRICE_W'(PRICE_MAX) : '0;
  endfunction

  // Input beats are taken here and fed to the model.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken_cnt++;
      predict_volatility(in_ch.close_price);
    end
  end

  // Result monitor: every beat is compared with the oldest expectation.
  always @(posedge clk) begin
    vol_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: volatility %0d marker_size %0d",
               out_ch.volatility, out_ch.marker_size);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_ch.volatility !== exp_res.vol) begin
          $error("volatility expected %0d actual %0d", exp_res.vol, out_ch.volatility);
          fail_count++;
        end
        if (out_ch.marker_size !== exp_res.marker) begin
          $error("marker_size expected %0d actual %0d", exp_res.marker, out_ch.marker_size);
          fail_count++;
        end
      end
    end
  end

  // Price driver: holds a beat until taken, then waits a random gap.
  int in_gap = 0;
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = 1'b0;
    if (in_ch.valid && taken_cnt != offered_cnt) begin
      nxt_valid = 1'b1;
    end else if (in_gap != 0) begin
      in_gap--;
    end else if (price_queue.size() != 0) begin
      nxt_valid = 1'b1;
      in_ch.close_price <= price_queue.pop_front();
      offered_cnt++;
      in_gap = idle_on ? $urandom_range(0, 5) : 0;
    end
    in_ch.valid <= nxt_valid;
  end

  // Result receiver: random stalls per beat and one long hold-off.
  int   out_stall  = 0;
  int   hold_left  = 0;
  int   ready_base = 0;
  logic hold_done  = 1'b0;
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (!hold_done && result_cnt >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (out_ch.ready && result_cnt == ready_base) begin
      nxt_ready = 1'b1;
    end else if (out_stall != 0) begin
      out_stall--;
    end else begin
      nxt_ready  = 1'b1;
      ready_base = result_cnt;
      out_stall  = idle_on ? $urandom_range(0, 5) : 0;
    end
    out_ch.ready <= nxt_ready;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wait until every price is taken and every result has come back, then let
  // the block finish any price that gives no result.
  task automatic wait_quiet();
    while (price_queue.size() != 0 || taken_cnt != offered_cnt ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A window write also clears the history in the model.
  task automatic write_window(logic [CFG_W-1:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    win_n = window_from_reg(value);
    clear_window_history();
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) price_queue.push_back(next_price());
  endtask

  int rand_windows[9];
  int rand_counts[9] = '{300, 80, 80, 100, 100, 100, 100, 60, 160};
  logic rand_idle[9] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.close_price = '0;
    out_ch.ready      = 1'b0;
    win_n = window_from_reg(DEFAULT_WINDOW);
    clear_window_history();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window: rail-to-rail swings push the marker to its cap, then
    // flat and single-step prices follow.
    price_queue = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
                    24'hFFFFFF, 24'hFFFFFF, 24'h000100, 24'h000101, 24'h000101};
    // Shortest window wraps the ring every other price.
    write_window(9'd2);
    price_queue = '{24'h001000, 24'h001100, 24'h001000, 24'h001000, 24'h001003,
                    24'h001003};
    // A window of one falls back to the default length.
    write_window(9'd1);
    price_queue = '{24'h800000, 24'h800001, 24'h7FFFFF, 24'h800000};

    rand_windows = '{256, 2, 0, 5, 0, 0, 0, 1, 0};
    rand_windows[4] = $urandom_range(2, 64);
    rand_windows[5] = $urandom_range(2, 64);
    rand_windows[6] = $urandom_range(2, 64);
    rand_windows[8] = $urandom_range(0, 256);
    for (int p = 0; p < 9; p++) begin
      write_window(CFG_W'(rand_windows[p]));
      idle_on = rand_idle[p];
      send_random(rand_counts[p]);
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/wrv_pkg.sv
sv/wrv_ifs.sv
sv/windowed_realized_volatility.sv
tb/testbench.sv
